>>> design/tmca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmca_pkg
// Types and constants for the tree minimum-cost slot assignment block.
// ----------------------------------------------------------------------------
package tmca_pkg;

  localparam int NodeW   = 10;
  localparam int SlotW   = 16;
  localparam int FlowW   = 17;
  localparam int DistW   = 7;
  localparam int TotalW  = 32;
  localparam int MemDepth = 1 << NodeW;

  localparam logic [NodeW-1:0]         NODE_COUNT_RST = 10'd1023;
  localparam logic signed [DistW-1:0]  DIST_INF = 7'sd63;
  localparam logic signed [DistW-1:0]  DIST_LIM = 7'sd62;
  localparam logic signed [FlowW-1:0]  FLOW_LIM = 17'sd65535;

  // One memory word holds everything kept per tree node.
  typedef struct packed {
    logic [SlotW-1:0]        slots;
    logic signed [FlowW-1:0] flow;
    logic signed [DistW-1:0] bdist;
    logic [NodeW-1:0]        bslot;
  } node_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_EV,
    ST_OP_A,
    ST_OP_B,
    ST_OP_C,
    ST_OP_D,
    ST_FINISH
  } state_t;

  // Path walks done by the node update sequencer.
  typedef enum logic [1:0] {
    PH_LOAD,
    PH_UP1,
    PH_UP2,
    PH_FIN
  } phase_t;

endpackage
`default_nettype wire

>>> design/tree_min_cost_assignment.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tree_min_cost_assignment
// Online minimum-distance assignment of requests to slots on a heap-indexed
// binary tree, kept in one node memory that is read, updated and written back.
// ----------------------------------------------------------------------------
//  channel  | signals                                | handshake
//  ---------+----------------------------------------+--------------------------
//  input    | func, node, slot_count                 | start & !busy
//  result   | total_cost, chosen_node, no_slot       | done, one cycle, no stall
//  config   | cfg_data (node_count)                  | cfg_valid & cfg_ready
//
// A load updates each node on the path from the node to the root. A request
// searches the node and its ancestors, a read and an evaluate state per node,
// then updates the nodes of its three path walks (at most 19 nodes). Each node
// update is a read of the node and its two children through the one read port
// of the memory and a write back. After reset a clearing pass over every word
// holds busy high. Results cannot be stalled; done pulses for one cycle.
module tree_min_cost_assignment (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic                          func,
  input  wire logic [tmca_pkg::NodeW-1:0]    node,
  input  wire logic [tmca_pkg::SlotW-1:0]    slot_count,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [tmca_pkg::NodeW-1:0]    cfg_data,
  output      logic                          done,
  output      logic [tmca_pkg::TotalW-1:0]   total_cost,
  output      logic [tmca_pkg::NodeW-1:0]    chosen_node,
  output      logic                          no_slot
);

  tmca_pkg::node_word_t mem [tmca_pkg::MemDepth];
  tmca_pkg::node_word_t rdata;
  tmca_pkg::node_word_t wdata;
  tmca_pkg::node_word_t self_w;
  tmca_pkg::node_word_t c0_w;
  tmca_pkg::node_word_t new_w;
  logic                         mem_we;
  logic [tmca_pkg::NodeW-1:0]   raddr;
  logic [tmca_pkg::NodeW-1:0]   waddr;

  tmca_pkg::state_t state, state_next;
  tmca_pkg::phase_t phase;

  logic [tmca_pkg::NodeW-1:0]   node_count;
  logic [tmca_pkg::NodeW-1:0]   clr_addr;
  logic [tmca_pkg::NodeW-1:0]   cur;
  logic [tmca_pkg::NodeW-1:0]   req_node;
  logic [tmca_pkg::NodeW-1:0]   pos;
  logic [tmca_pkg::NodeW-1:0]   slot;
  logic [tmca_pkg::SlotW-1:0]   cnt;
  logic signed [8:0]            best;
  logic signed [7:0]            val;
  logic                         found;
  logic                         set_pending;
  logic                         dec_pending;
  logic [tmca_pkg::TotalW-1:0]  running_total;
  logic [tmca_pkg::NodeW-1:0]   res_node;
  logic                         res_no_slot;

  // Memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // ---------------------------------------------------------------- node update
  logic [tmca_pkg::NodeW:0]     c0_idx;
  logic [tmca_pkg::NodeW:0]     c1_idx;
  logic                         c0_ok;
  logic                         c1_ok;
  logic [tmca_pkg::NodeW-1:0]   up_node;
  logic                         dec_use;
  logic                         up2_go;
  logic                         op_more;

  function automatic logic signed [6:0] child_cost(input tmca_pkg::node_word_t w);
    logic signed [7:0] s;
    s = {w.bdist[6], w.bdist} + (w.flow[16] ? 8'hFF : 8'h01);
    if (s > 8'sd62) begin
      s = 8'sd62;
    end else if (s < -8'sd62) begin
      s = -8'sd62;
    end
    return s[6:0];
  endfunction

  assign c0_idx  = {cur, 1'b0};
  assign c1_idx  = {cur, 1'b1};
  assign c0_ok   = c0_idx <= {1'b0, node_count};
  assign c1_ok   = c1_idx <= {1'b0, node_count};
  assign up_node = cur >> 1;
  assign dec_use = dec_pending && (cur == slot) &&
                   ((phase == tmca_pkg::PH_UP2) || (phase == tmca_pkg::PH_FIN));
  assign up2_go  = (slot != pos) && (slot != '0);

  always_comb begin
    logic signed [17:0] fs;
    logic signed [17:0] delta;
    logic signed [6:0]  rd_dist;
    logic signed [6:0]  cand;
    logic [tmca_pkg::NodeW-1:0] rd_slot;
    logic               rd_fin;
    new_w = self_w;
    cand  = '0;
    unique case (phase)
      tmca_pkg::PH_UP1: delta = -18'sd1;
      tmca_pkg::PH_UP2: delta = 18'sd1;
      default:          delta = 18'sd0;
    endcase
    if (set_pending) begin
      new_w.slots = cnt;
    end else if (dec_use && (self_w.slots != '0)) begin
      new_w.slots = self_w.slots - 16'd1;
    end
    fs = {self_w.flow[16], self_w.flow} + delta;
    if (fs > 18'sd65535) begin
      new_w.flow = tmca_pkg::FLOW_LIM;
    end else if (fs < -18'sd65535) begin
      new_w.flow = -tmca_pkg::FLOW_LIM;
    end else begin
      new_w.flow = fs[16:0];
    end
    rd_dist = tmca_pkg::DIST_INF;
    rd_slot = '0;
    rd_fin  = 1'b0;
    if (new_w.slots != '0) begin
      rd_dist = 7'sd0;
      rd_slot = cur;
      rd_fin  = 1'b1;
    end
    if (c0_ok && (c0_w.bdist != tmca_pkg::DIST_INF)) begin
      cand = child_cost(c0_w);
      if (!rd_fin || (cand < rd_dist)) begin
        rd_dist = cand;
        rd_slot = c0_w.bslot;
        rd_fin  = 1'b1;
      end
    end
    if (c1_ok && (rdata.bdist != tmca_pkg::DIST_INF)) begin
      cand = child_cost(rdata);
      if (!rd_fin || (cand < rd_dist)) begin
        rd_dist = cand;
        rd_slot = rdata.bslot;
      end
    end
    // Nodes beyond the node count keep their stored summary.
    if (cur <= node_count) begin
      new_w.bdist = rd_dist;
      new_w.bslot = rd_slot;
    end
  end

  always_comb begin
    unique case (phase)
      tmca_pkg::PH_LOAD, tmca_pkg::PH_FIN: op_more = up_node != '0;
      default:                             op_more = 1'b1;
    endcase
  end

  // -------------------------------------------------------------------- search
  logic signed [8:0]            cc;
  logic                         take;
  logic signed [7:0]            cost_up;
  logic signed [8:0]            best_f;
  logic [tmca_pkg::NodeW-1:0]   pos_f;
  logic [tmca_pkg::NodeW-1:0]   slot_f;
  logic                         found_f;
  logic signed [33:0]           tsum;
  logic [tmca_pkg::TotalW-1:0]  total_f;
  logic                         node_ok;

  assign cc      = {val[7], val} + {{2{rdata.bdist[6]}}, rdata.bdist};
  assign take    = (rdata.bdist != tmca_pkg::DIST_INF) && (!found || (cc < best));
  assign cost_up = (!rdata.flow[16] && (rdata.flow != '0)) ? -8'sd1 : 8'sd1;
  assign best_f  = take ? cc : best;
  assign pos_f   = take ? cur : pos;
  assign slot_f  = take ? rdata.bslot : slot;
  assign found_f = take || found;
  assign tsum    = {2'b00, running_total} + {{25{best_f[8]}}, best_f};
  assign node_ok = (node != '0) && (node <= node_count);

  always_comb begin
    if (tsum[33]) begin
      total_f = '0;
    end else if (tsum[32]) begin
      total_f = '1;
    end else begin
      total_f = tsum[31:0];
    end
  end

  // --------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      tmca_pkg::ST_CLEAR:   if (clr_addr == '1) state_next = tmca_pkg::ST_IDLE;
      tmca_pkg::ST_IDLE: begin
        if (start) begin
          if (!node_ok) begin
            state_next = tmca_pkg::ST_FINISH;
          end else if (func) begin
            state_next = tmca_pkg::ST_SRCH_RD;
          end else begin
            state_next = tmca_pkg::ST_OP_A;
          end
        end
      end
      tmca_pkg::ST_SRCH_RD: state_next = tmca_pkg::ST_SRCH_EV;
      tmca_pkg::ST_SRCH_EV: begin
        if (up_node != '0) begin
          state_next = tmca_pkg::ST_SRCH_RD;
        end else if (found_f) begin
          state_next = tmca_pkg::ST_OP_A;
        end else begin
          state_next = tmca_pkg::ST_FINISH;
        end
      end
      tmca_pkg::ST_OP_A:    state_next = tmca_pkg::ST_OP_B;
      tmca_pkg::ST_OP_B:    state_next = tmca_pkg::ST_OP_C;
      tmca_pkg::ST_OP_C:    state_next = tmca_pkg::ST_OP_D;
      tmca_pkg::ST_OP_D:    state_next = op_more ? tmca_pkg::ST_OP_A : tmca_pkg::ST_FINISH;
      tmca_pkg::ST_FINISH:  state_next = tmca_pkg::ST_IDLE;
      default:              state_next = tmca_pkg::ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------ memory control
  always_comb begin
    mem_we = 1'b0;
    waddr  = cur;
    wdata  = new_w;
    raddr  = cur;
    unique case (state)
      tmca_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_addr;
        wdata  = '{slots: '0, flow: '0, bdist: tmca_pkg::DIST_INF, bslot: '0};
      end
      tmca_pkg::ST_OP_B: raddr = c0_idx[tmca_pkg::NodeW-1:0];
      tmca_pkg::ST_OP_C: raddr = c1_idx[tmca_pkg::NodeW-1:0];
      tmca_pkg::ST_OP_D: mem_we = 1'b1;
      default: ;
    endcase
  end

  assign busy      = state != tmca_pkg::ST_IDLE;
  assign cfg_ready = 1'b1;

  // ------------------------------------------------------------------ datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tmca_pkg::ST_CLEAR;
      clr_addr      <= '0;
      node_count    <= tmca_pkg::NODE_COUNT_RST;
      running_total <= '0;
      done          <= 1'b0;
      set_pending   <= 1'b0;
      dec_pending   <= 1'b0;
      phase         <= tmca_pkg::PH_LOAD;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      unique case (state)
        tmca_pkg::ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        tmca_pkg::ST_IDLE: begin
          if (start) begin
            req_node    <= node;
            cur         <= node;
            cnt         <= slot_count;
            val         <= '0;
            found       <= 1'b0;
            res_node    <= '0;
            res_no_slot <= func && !node_ok;
            set_pending <= !func;
            dec_pending <= 1'b0;
            phase       <= tmca_pkg::PH_LOAD;
          end
        end
        tmca_pkg::ST_SRCH_EV: begin
          best  <= best_f;
          pos   <= pos_f;
          slot  <= slot_f;
          found <= found_f;
          val   <= val + cost_up;
          if (up_node != '0) begin
            cur <= up_node;
          end else if (!found_f) begin
            res_no_slot <= 1'b1;
          end else begin
            // Walks: request node up to the chosen ancestor, then slot up to it,
            // then the ancestor up to the root.
            running_total <= total_f;
            res_node      <= slot_f;
            dec_pending   <= slot_f != '0;
            if (req_node != pos_f) begin
              phase <= tmca_pkg::PH_UP1;
              cur   <= req_node;
            end else if ((slot_f != pos_f) && (slot_f != '0)) begin
              phase <= tmca_pkg::PH_UP2;
              cur   <= slot_f;
            end else begin
              phase <= tmca_pkg::PH_FIN;
              cur   <= pos_f;
            end
          end
        end
        tmca_pkg::ST_OP_B: self_w <= rdata;
        tmca_pkg::ST_OP_C: c0_w   <= rdata;
        tmca_pkg::ST_OP_D: begin
          set_pending <= 1'b0;
          if (dec_use) begin
            dec_pending <= 1'b0;
          end
          unique case (phase)
            tmca_pkg::PH_LOAD, tmca_pkg::PH_FIN: cur <= up_node;
            tmca_pkg::PH_UP1: begin
              if ((up_node != pos) && (up_node != '0)) begin
                cur <= up_node;
              end else if (up2_go) begin
                phase <= tmca_pkg::PH_UP2;
                cur   <= slot;
              end else begin
                phase <= tmca_pkg::PH_FIN;
                cur   <= pos;
              end
            end
            tmca_pkg::PH_UP2: begin
              if ((up_node != pos) && (up_node != '0)) begin
                cur <= up_node;
              end else begin
                phase <= tmca_pkg::PH_FIN;
                cur   <= pos;
              end
            end
            default: ;
          endcase
        end
        tmca_pkg::ST_FINISH: begin
          done        <= 1'b1;
          total_cost  <= running_total;
          chosen_node <= res_node;
          no_slot     <= res_no_slot;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/tmca_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmca_checker
// Port-level checks for the tree minimum-cost slot assignment block.
// ----------------------------------------------------------------------------
module tmca_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done,
  input wire logic [tmca_pkg::NodeW-1:0]  chosen_node,
  input wire logic                        no_slot
);

  // A result is only shown once the block has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // An accepted item always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  // A failed request never names a slot.
  a_no_slot_node: assert property (@(posedge clk) disable iff (rst)
    (done && no_slot) |-> (chosen_node == '0))
    else $error("failed request reports a node");

  // Each item gives one single-cycle result.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

bind tree_min_cost_assignment tmca_checker u_tmca_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .chosen_node (chosen_node),
  .no_slot     (no_slot)
);
`default_nettype wire
